/* rtl/cbs_pkg.sv */
// Shared types, constants and helpers for the CPU burst scheduler.
// No dependencies.
package cbs_pkg;

  localparam int unsigned MaxJobsDef   = 32;
  localparam int unsigned MaxBurstsDef = 32;
  localparam int unsigned ApbDataW     = 32;
  localparam int unsigned ApbAddrW     = 3;

  typedef logic [15:0] tick_t;
  typedef logic [11:0] blen_t;
  typedef logic [7:0]  byte_t;
  typedef logic [31:0] total_t;
  typedef logic [1:0]  mode_t;

  localparam tick_t SliceReset = 16'd25;

  // register indexes
  localparam logic RegPolicy = 1'b0;
  localparam logic RegSlice  = 1'b1;

  // policy codes
  localparam mode_t PolFcfs   = 2'd0;
  localparam mode_t PolRr     = 2'd1;
  localparam mode_t PolPri    = 2'd2;
  localparam mode_t PolPriAlt = 2'd3;

  typedef struct packed {
    logic  op;
    byte_t job_id;
    byte_t job_priority;
    tick_t arrival_time;
    blen_t burst_length;
    logic  job_last_burst;
  } req_t;

  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  function automatic total_t sat_add(total_t a, total_t b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

endpackage

/* rtl/cbs_if.sv */
// Request and result channel interfaces of the CPU burst scheduler.
// Depends on cbs_pkg.
interface cbs_req_if import cbs_pkg::*; ;
  logic  valid;
  logic  ready;
  logic  op;
  byte_t job_id;
  byte_t job_priority;
  tick_t arrival_time;
  blen_t burst_length;
  logic  job_last_burst;

  modport source (output valid, op, job_id, job_priority, arrival_time, burst_length,
                  job_last_burst, input ready);
  modport sink (input valid, op, job_id, job_priority, arrival_time, burst_length,
                job_last_burst, output ready);
endinterface

interface cbs_rsp_if import cbs_pkg::*; ;
  logic       valid;
  logic       ready;
  logic       dispatched;
  byte_t      running_job_id;
  tick_t      current_time;
  logic [5:0] ready_count;
  logic       all_done;
  total_t     total_waiting;
  total_t     total_turnaround;
  logic       load_error;

  modport source (output valid, dispatched, running_job_id, current_time, ready_count,
                  all_done, total_waiting, total_turnaround, load_error, input ready);
  modport sink (input valid, dispatched, running_job_id, current_time, ready_count,
                all_done, total_waiting, total_turnaround, load_error, output ready);
endinterface

/* rtl/cpu_burst_scheduler_sim.sv */
// CPU burst scheduler: job tables, wait list, ready queue, sequencer.
// Depends on cbs_pkg and cbs_if.
//
//   channel  dir  handshake      carries
//   req_i    in   valid/ready    load of one burst, or one time tick
//   rsp_o    out  valid/ready    one result per request
//   apb      in   psel/penable   policy_mode (0x0), time_slice (0x4)
//
// Load: S_LOAD then S_OUT. A tick scans the W wait-list entries, then R
// ready entries (all in priority mode and one otherwise), then makes S queue
// shifts; the job, list and burst memories each have one read port and are
// read one entry per step. A tick with no dispatch skips the ready scan.
// Reset clears control state only; table memories need no clearing.
// The result register lets a new request in while a result waits.
module cpu_burst_scheduler_sim import cbs_pkg::*; #(
  parameter int unsigned MAX_JOBS   = MaxJobsDef,
  parameter int unsigned MAX_BURSTS = MaxBurstsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cbs_req_if.sink             req_i,
  cbs_rsp_if.source           rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int JW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW  = $clog2(MAX_JOBS + 1);
  localparam int BW  = (MAX_BURSTS > 1) ? $clog2(MAX_BURSTS) : 1;
  localparam int NBW = $clog2(MAX_BURSTS + 1);
  localparam int CPW = $clog2(MAX_BURSTS + 2);
  localparam int SW  = 12 + NBW;
  localparam int BDEPTH = MAX_JOBS * (2 ** BW);

  typedef struct packed {
    byte_t          id;
    byte_t          pri;
    tick_t          due;
    logic [NBW-1:0] nb;
    logic [CPW-1:0] cpu;
  } jent_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_WS_A, S_WS_B, S_WS_C, S_END, S_PS_A, S_PS_B, S_PS_C,
    S_SH_A, S_SH_B, S_DP_A, S_DP_B, S_DP_C, S_DP_D, S_TOT, S_OUT
  } state_e;

  state_e state_q;
  req_t   in_q;
  mode_t  policy_mode_q;
  tick_t  time_slice_q;

  logic [CW-1:0]  job_count_q, jobs_left_q, wait_len_q, ready_len_q, idx_q, k_q, best_pos_q;
  logic           job_open_q;
  byte_t          open_id_q, open_pri_q;
  tick_t          open_due_q;
  logic [NBW-1:0] open_nb_q;
  logic [SW-1:0]  open_sum_q;
  logic           cpu_busy_q, run_pre_q, run_done_q;
  logic [JW-1:0]  run_job_q, cur_j_q, best_j_q;
  tick_t          run_end_q, now_q, t_q;
  total_t         tw_q, tt_q;
  byte_t          best_pri_q;
  logic [BW-1:0]  c_q;
  jent_t          ent_q;
  logic           disp_q, err_q;
  byte_t          rid_q;

  logic       out_valid_q, out_disp_q, out_done_q, out_err_q;
  byte_t      out_rid_q;
  tick_t      out_time_q;
  logic [5:0] out_cnt_q;
  total_t     out_tw_q, out_tt_q;

  // memories
  blen_t         bmem [BDEPTH];
  jent_t         jmem [MAX_JOBS];
  logic [JW-1:0] wlmem [MAX_JOBS];
  logic [JW-1:0] rfmem [MAX_JOBS];

  logic             b_we, j_we, wl_we, rf_we;
  logic [JW+BW-1:0] b_wa, b_ra;
  blen_t            b_wd, b_rd_q;
  logic [JW-1:0]    j_ra, j_wa, wl_wa, rf_wa, rf_ra, wl_wd, rf_wd, wl_rd_q, rf_rd_q;
  jent_t            j_wd, j_rd_q;

  always_ff @(posedge clk_i) begin
    if (b_we) bmem[b_wa] <= b_wd;
    b_rd_q <= bmem[b_ra];
  end

  always_ff @(posedge clk_i) begin
    if (j_we) jmem[j_wa] <= j_wd;
    j_rd_q <= jmem[j_ra];
  end

  always_ff @(posedge clk_i) begin
    if (wl_we) wlmem[wl_wa] <= wl_wd;
    wl_rd_q <= wlmem[idx_q[JW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rfmem[rf_wa] <= rf_wd;
    rf_rd_q <= rfmem[rf_ra];
  end

  // load datapath
  logic           ld_new, ld_full, ld_berr, ld_close;
  logic [JW-1:0]  ld_j;
  logic [NBW-1:0] ld_nb, ld_nb_n;
  blen_t          ld_len;
  logic [SW-1:0]  ld_sum;
  byte_t          ld_id, ld_pri;
  tick_t          ld_due;

  assign ld_new   = !job_open_q;
  assign ld_full  = ld_new && (job_count_q >= CW'(MAX_JOBS));
  assign ld_j     = ld_new ? job_count_q[JW-1:0] : JW'(job_count_q - 1'b1);
  assign ld_nb    = ld_new ? '0 : open_nb_q;
  assign ld_len   = (in_q.burst_length == '0) ? blen_t'(1) : in_q.burst_length;
  assign ld_berr  = ld_nb >= NBW'(MAX_BURSTS);
  assign ld_nb_n  = ld_berr ? ld_nb : NBW'(ld_nb + 1'b1);
  assign ld_sum   = (ld_new ? '0 : open_sum_q) + (ld_berr ? '0 : SW'(ld_len));
  assign ld_close = !ld_full && in_q.job_last_burst;
  assign ld_id    = ld_new ? in_q.job_id : open_id_q;
  assign ld_pri   = ld_new ? in_q.job_priority : open_pri_q;
  assign ld_due   = ld_new ? in_q.arrival_time : open_due_q;

  // tick datapath
  logic           wl_room, rf_room, ws_hit, slice_end, end_push, pri_mode, ps_take;
  logic [CW-1:0]  rl_after_end, ps_pos;
  logic [BW-1:0]  c_calc;
  tick_t          lim, s16;
  blen_t          dp_s, dp_rem;
  logic [CPW-1:0] dp_cpu_new;
  logic           dp_fin, dp_more;
  jent_t          dp_ent;

  assign wl_room   = wait_len_q < CW'(MAX_JOBS);
  assign rf_room   = ready_len_q < CW'(MAX_JOBS);
  assign ws_hit    = j_rd_q.due == now_q;
  assign slice_end = cpu_busy_q && (now_q == run_end_q);
  assign end_push  = slice_end && !run_done_q && run_pre_q && rf_room;
  assign rl_after_end = ready_len_q + CW'(end_push);
  assign pri_mode  = (policy_mode_q == PolPri) || (policy_mode_q == PolPriAlt);
  assign ps_take   = (idx_q == '0) || (pri_mode && (j_rd_q.pri < best_pri_q));
  assign ps_pos    = ps_take ? idx_q : best_pos_q;
  assign c_calc    = (j_rd_q.cpu >= CPW'(MAX_BURSTS)) ? BW'(MAX_BURSTS - 1) : j_rd_q.cpu[BW-1:0];
  assign lim       = (time_slice_q == '0) ? tick_t'(1) : time_slice_q;
  assign s16       = ((policy_mode_q != PolFcfs) && (tick_t'(b_rd_q) > lim)) ? lim
                                                                             : tick_t'(b_rd_q);
  assign dp_s       = s16[11:0];
  assign dp_rem     = b_rd_q - dp_s;
  assign dp_fin     = dp_rem == '0;
  assign dp_cpu_new = CPW'(c_q) + CPW'(2);
  assign dp_more    = dp_fin && (dp_cpu_new < CPW'(ent_q.nb));

  always_comb begin
    dp_ent = ent_q;
    if (dp_fin) dp_ent.cpu = dp_cpu_new;
  end

  always_comb begin
    b_we  = 1'b0;
    b_wa  = {ld_j, ld_nb[BW-1:0]};
    b_wd  = ld_len;
    b_ra  = {best_j_q, c_calc};
    j_we  = 1'b0;
    j_wa  = best_j_q;
    j_wd  = ent_q;
    j_ra  = best_j_q;
    wl_we = 1'b0;
    wl_wa = wait_len_q[JW-1:0];
    wl_wd = best_j_q;
    rf_we = 1'b0;
    rf_wa = ready_len_q[JW-1:0];
    rf_wd = cur_j_q;
    rf_ra = (state_q == S_SH_A) ? JW'(idx_q + 1'b1) : idx_q[JW-1:0];
    unique case (state_q)
      S_LOAD: begin
        b_we = !ld_full && !ld_berr;
        if (ld_close) begin
          j_we       = 1'b1;
          j_wa       = ld_j;
          j_wd.id    = ld_id;
          j_wd.pri   = ld_pri;
          j_wd.due   = ld_due;
          j_wd.nb    = ld_nb_n;
          j_wd.cpu   = '0;
          wl_we      = wl_room;
          wl_wd      = ld_j;
        end
      end
      S_WS_B: j_ra = wl_rd_q;
      S_WS_C: begin
        if (ws_hit) begin
          rf_we = rf_room;
        end else begin
          wl_we = 1'b1;
          wl_wa = k_q[JW-1:0];
          wl_wd = cur_j_q;
        end
      end
      S_END: begin
        rf_we = end_push;
        rf_wd = run_job_q;
      end
      S_PS_B: j_ra = rf_rd_q;
      S_SH_B: begin
        rf_we = 1'b1;
        rf_wa = idx_q[JW-1:0];
        rf_wd = rf_rd_q;
      end
      S_DP_C: begin
        b_we = 1'b1;
        b_wa = {best_j_q, c_q};
        b_wd = dp_rem;
        b_ra = {best_j_q, BW'(c_q + 1'b1)};
        j_we = !dp_more;
        j_wd = dp_ent;
      end
      S_DP_D: begin
        j_we     = 1'b1;
        j_wd.due = run_end_q + tick_t'(b_rd_q);
        wl_we    = wl_room;
      end
      default: ;
    endcase
  end

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSlice) ? ApbDataW'(time_slice_q) : ApbDataW'(policy_mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_mode_q <= PolRr;
      time_slice_q  <= SliceReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegSlice) time_slice_q <= pwdata[15:0];
      else policy_mode_q <= pwdata[1:0];
    end
  end

  assign req_i.ready = state_q == S_IDLE;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_count_q <= '0;
      jobs_left_q <= '0;
      wait_len_q  <= '0;
      ready_len_q <= '0;
      job_open_q  <= 1'b0;
      cpu_busy_q  <= 1'b0;
      run_pre_q   <= 1'b0;
      run_done_q  <= 1'b0;
      run_end_q   <= '0;
      run_job_q   <= '0;
      now_q       <= '0;
      tw_q        <= '0;
      tt_q        <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
    end else begin
      if ((state_q != S_OUT) && rsp_o.valid && rsp_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            in_q.op             <= req_i.op;
            in_q.job_id         <= req_i.job_id;
            in_q.job_priority   <= req_i.job_priority;
            in_q.arrival_time   <= req_i.arrival_time;
            in_q.burst_length   <= req_i.burst_length;
            in_q.job_last_burst <= req_i.job_last_burst;
            t_q    <= now_q;
            disp_q <= 1'b0;
            rid_q  <= '0;
            err_q  <= 1'b0;
            idx_q  <= '0;
            k_q    <= '0;
            if (req_i.op == OpLoad) state_q <= S_LOAD;
            else if (wait_len_q == '0) state_q <= S_END;
            else state_q <= S_WS_A;
          end
        end
        S_LOAD: begin
          err_q <= ld_full || ld_berr;
          if (!ld_full) begin
            if (ld_new) begin
              job_count_q <= job_count_q + 1'b1;
              open_id_q   <= in_q.job_id;
              open_pri_q  <= in_q.job_priority;
              open_due_q  <= in_q.arrival_time;
            end
            open_nb_q  <= ld_nb_n;
            open_sum_q <= ld_sum;
            if (in_q.job_last_burst) begin
              job_open_q  <= 1'b0;
              jobs_left_q <= jobs_left_q + 1'b1;
              tt_q        <= sat_add(tt_q, total_t'(ld_sum));
              if (wl_room) wait_len_q <= wait_len_q + 1'b1;
            end else begin
              job_open_q <= 1'b1;
            end
          end
          state_q <= S_OUT;
        end
        S_WS_A: state_q <= S_WS_B;
        S_WS_B: begin
          cur_j_q <= wl_rd_q;
          state_q <= S_WS_C;
        end
        S_WS_C: begin
          if (ws_hit) begin
            if (rf_room) ready_len_q <= ready_len_q + 1'b1;
          end else begin
            k_q <= k_q + 1'b1;
          end
          idx_q <= idx_q + 1'b1;
          if (CW'(idx_q + 1'b1) == wait_len_q) begin
            wait_len_q <= ws_hit ? k_q : CW'(k_q + 1'b1);
            state_q    <= S_END;
          end else begin
            state_q <= S_WS_A;
          end
        end
        S_END: begin
          if (slice_end) begin
            cpu_busy_q <= 1'b0;
            run_pre_q  <= 1'b0;
            if (run_done_q && (jobs_left_q != '0)) jobs_left_q <= jobs_left_q - 1'b1;
          end
          ready_len_q <= rl_after_end;
          idx_q       <= '0;
          if ((!cpu_busy_q || slice_end) && (rl_after_end != '0)) state_q <= S_PS_A;
          else state_q <= S_TOT;
        end
        S_PS_A: state_q <= S_PS_B;
        S_PS_B: begin
          cur_j_q <= rf_rd_q;
          state_q <= S_PS_C;
        end
        S_PS_C: begin
          if (ps_take) begin
            best_pri_q <= j_rd_q.pri;
            best_j_q   <= cur_j_q;
            best_pos_q <= idx_q;
          end
          if (!pri_mode || (CW'(idx_q + 1'b1) == ready_len_q)) begin
            idx_q <= ps_pos;
            if (CW'(ps_pos + 1'b1) < ready_len_q) begin
              state_q <= S_SH_A;
            end else begin
              ready_len_q <= ready_len_q - 1'b1;
              state_q     <= S_DP_A;
            end
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_PS_A;
          end
        end
        S_SH_A: state_q <= S_SH_B;
        S_SH_B: begin
          idx_q <= idx_q + 1'b1;
          if ((CW+1)'(idx_q) + 2'd2 < (CW+1)'(ready_len_q)) begin
            state_q <= S_SH_A;
          end else begin
            ready_len_q <= ready_len_q - 1'b1;
            state_q     <= S_DP_A;
          end
        end
        S_DP_A: state_q <= S_DP_B;
        S_DP_B: begin
          ent_q   <= j_rd_q;
          c_q     <= c_calc;
          state_q <= S_DP_C;
        end
        S_DP_C: begin
          ent_q      <= dp_ent;
          run_end_q  <= now_q + s16;
          run_job_q  <= best_j_q;
          cpu_busy_q <= 1'b1;
          run_pre_q  <= !dp_fin;
          run_done_q <= dp_fin && !dp_more;
          disp_q     <= 1'b1;
          rid_q      <= ent_q.id;
          state_q    <= dp_more ? S_DP_D : S_TOT;
        end
        S_DP_D: begin
          if (wl_room) wait_len_q <= wait_len_q + 1'b1;
          state_q <= S_TOT;
        end
        S_TOT: begin
          tw_q    <= sat_add(tw_q, total_t'(ready_len_q));
          tt_q    <= sat_add(tt_q, total_t'(ready_len_q));
          now_q   <= now_q + 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_disp_q  <= disp_q;
            out_rid_q   <= rid_q;
            out_time_q  <= t_q;
            out_cnt_q   <= 6'(ready_len_q);
            out_done_q  <= (jobs_left_q == '0) && !job_open_q;
            out_tw_q    <= tw_q;
            out_tt_q    <= tt_q;
            out_err_q   <= err_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.dispatched       = out_disp_q;
  assign rsp_o.running_job_id   = out_rid_q;
  assign rsp_o.current_time     = out_time_q;
  assign rsp_o.ready_count      = out_cnt_q;
  assign rsp_o.all_done         = out_done_q;
  assign rsp_o.total_waiting    = out_tw_q;
  assign rsp_o.total_turnaround = out_tt_q;
  assign rsp_o.load_error       = out_err_q;

  a_ready_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_len_q <= CW'(MAX_JOBS) && wait_len_q <= CW'(MAX_JOBS))
    else $error("queue length beyond job table");

  a_dispatch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DP_C) |=> (cpu_busy_q && disp_q))
    else $error("dispatch did not occupy the cpu");

  a_jobs_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jobs_left_q <= job_count_q)
    else $error("more open jobs than loaded");

endmodule
